// ===== hw/rtl/wsenc_pkg.sv =====
// Shared types and fixed-point constants of the WS2812 color command encoder.
package wsenc_pkg;

    typedef enum logic [1:0] {
        KIND_RGB  = 2'd0,
        KIND_HUE  = 2'd1,
        KIND_TEMP = 2'd2,
        KIND_GRAY = 2'd3
    } t_kind;

    // Which piece of the hue function a channel falls on.
    typedef enum logic [1:0] {
        SEG_RISE = 2'd0,
        SEG_HIGH = 2'd1,
        SEG_FALL = 2'd2,
        SEG_LOW  = 2'd3
    } t_seg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Q16 fractions, 1.0 = 65536.
    localparam logic [16:0] Q_ONE      = 17'd65536;
    localparam logic [16:0] Q_SIXTH    = 17'd10922;
    localparam logic [16:0] Q_THIRD    = 17'd21845;
    localparam logic [16:0] Q_HALF     = 17'd32768;
    localparam logic [16:0] Q_TWOTHIRD = 17'd43690;
    localparam logic [16:0] Q_H_TEMP   = 17'd5439;
    localparam logic [14:0] Q_TEMP_K   = 15'd26214;

    localparam logic [7:0]  SAT_MAX    = 8'd254;
    localparam logic [15:0] TEMP_MAX   = 16'd500;
    // (t << 16) / 500 = t * 131 + floor(9 * t / 125), and the last term is
    // taken as (t * 9 * 8389) >> 20, exact for t up to 500.
    localparam logic [15:0] TEMP_STEP  = 16'd131;
    localparam logic [16:0] TEMP_RECIP = 17'd75501;

    localparam logic [3:0]  LAST_BYTE  = 4'd8;

endpackage

// ===== hw/rtl/wsenc_front.sv =====
// Front end: accepts color commands and converts them to RGB in a five-stage pipeline.
module wsenc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    input  logic [7:0]        i_hue,
    input  logic [7:0]        i_saturation,
    input  logic [15:0]       i_color_temp,
    input  logic [7:0]        i_level,
    output logic              o_valid,
    input  logic              i_ready,
    output wsenc_pkg::t_rgb   o_rgb
);
    import wsenc_pkg::*;

    // x * 65536 / 254 for an 8-bit x: 65536 / 254 = 258 + 2 / 127.
    function automatic logic [16:0] div254(input logic [7:0] x);
        logic [8:0]  x2;
        logic [2:0]  corr;
        x2 = {x, 1'b0};
        if (x2 >= 9'd508) begin
            corr = 3'd4;
        end else if (x2 >= 9'd381) begin
            corr = 3'd3;
        end else if (x2 >= 9'd254) begin
            corr = 3'd2;
        end else if (x2 >= 9'd127) begin
            corr = 3'd1;
        end else begin
            corr = 3'd0;
        end
        return 17'({x, 8'd0}) + 17'({x, 1'b0}) + 17'(corr);
    endfunction

    logic en1, en2, en3, en4, en5;

    // Stage 1: hue and saturation scaling, temperature reciprocal product.
    logic        r1_v;
    t_kind       r1_kind, n1_kind;
    t_rgb        r1_rgb, n1_rgb;
    logic [16:0] r1_h, n1_h;
    logic [16:0] r1_f1, n1_f1;
    logic [15:0] r1_cb, n1_cb;
    logic [5:0]  r1_rq, n1_rq;

    // Stage 2: p for hue commands, fraction for temperature, wrapped hues.
    logic        r2_v;
    t_kind       r2_kind;
    t_rgb        r2_rgb;
    logic [16:0] r2_pf, n2_pf;
    logic [16:0] r2_t [3];
    logic [16:0] n2_t [3];

    // Stage 3: lightness product for temperature commands.
    logic        r3_v;
    t_kind       r3_kind;
    t_rgb        r3_rgb;
    logic [16:0] r3_pk, n3_pk;
    logic [16:0] r3_t [3];

    // Stage 4: p, q - p, segment and slope factor per channel.
    logic        r4_v;
    t_kind       r4_kind;
    t_rgb        r4_rgb;
    logic [16:0] r4_p, n4_p;
    logic [16:0] r4_d, n4_d;
    logic [15:0] r4_k [3];
    logic [15:0] n4_k [3];
    t_seg        r4_seg [3];
    t_seg        n4_seg [3];

    // Stage 5: ramp products.
    logic        r5_v;
    t_kind       r5_kind;
    t_rgb        r5_rgb;
    logic [16:0] r5_p;
    logic [15:0] r5_ph [3];
    logic [15:0] n5_ph [3];
    t_seg        r5_seg [3];

    assign en5 = !r5_v || i_ready;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign o_ready = en1;

    always_comb begin
        logic [7:0]  sat_c;
        logic [8:0]  ct_c;
        logic [25:0] rq_full;
        n1_kind = t_kind'(i_kind);
        if (n1_kind == KIND_GRAY) begin
            n1_rgb = '{red: i_level, green: i_level, blue: i_level};
        end else begin
            n1_rgb = '{red: i_red, green: i_green, blue: i_blue};
        end
        sat_c = (i_saturation > SAT_MAX) ? SAT_MAX : i_saturation;
        ct_c  = (i_color_temp > TEMP_MAX) ? TEMP_MAX[8:0] : i_color_temp[8:0];
        n1_h  = (n1_kind == KIND_TEMP) ? Q_H_TEMP : div254(i_hue);
        n1_f1 = div254(sat_c);
        n1_cb = 16'(16'(ct_c) * TEMP_STEP);
        rq_full = 26'(ct_c) * 26'(TEMP_RECIP);
        n1_rq = rq_full[25:20];
    end

    always_comb begin
        logic [16:0] f2;
        logic [16:0] p1;
        logic [16:0] tr;
        f2 = 17'(r1_cb) + 17'(r1_rq);
        p1 = Q_ONE - {r1_f1[16:1], 1'b0};
        n2_pf = (r1_kind == KIND_TEMP) ? f2 : p1;
        tr = r1_h + Q_THIRD;
        n2_t[0] = (tr > Q_ONE) ? tr - Q_ONE : tr;
        n2_t[1] = (r1_h > Q_ONE) ? r1_h - Q_ONE : r1_h;
        n2_t[2] = (r1_h < Q_THIRD) ? r1_h + (Q_ONE - Q_THIRD) : r1_h - Q_THIRD;
    end

    always_comb begin
        logic [31:0] m;
        m = 32'(r2_pf) * 32'(Q_TEMP_K);
        n3_pk = (r2_kind == KIND_TEMP) ? {2'd0, m[30:16]} : r2_pf;
    end

    always_comb begin
        logic [16:0] e;
        n4_p = (r3_kind == KIND_TEMP) ? Q_ONE - {r3_pk[15:0], 1'b0} : r3_pk;
        n4_d = Q_ONE - n4_p;
        for (int c = 0; c < 3; c++) begin
            e = Q_TWOTHIRD - r3_t[c];
            if (r3_t[c] < Q_SIXTH) begin
                n4_seg[c] = SEG_RISE;
                n4_k[c]   = {r3_t[c][13:0], 2'b0} + {1'b0, r3_t[c][13:0], 1'b0};
            end else if (r3_t[c] < Q_HALF) begin
                n4_seg[c] = SEG_HIGH;
                n4_k[c]   = '0;
            end else if (r3_t[c] < Q_TWOTHIRD) begin
                n4_seg[c] = SEG_FALL;
                n4_k[c]   = {e[13:0], 2'b0} + {1'b0, e[13:0], 1'b0};
            end else begin
                n4_seg[c] = SEG_LOW;
                n4_k[c]   = '0;
            end
        end
    end

    always_comb begin
        logic [32:0] pr;
        for (int c = 0; c < 3; c++) begin
            pr = 33'(r4_d) * 33'(r4_k[c]);
            n5_ph[c] = pr[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_kind <= n1_kind;
            r1_rgb  <= n1_rgb;
            r1_h    <= n1_h;
            r1_f1   <= n1_f1;
            r1_cb   <= n1_cb;
            r1_rq   <= n1_rq;
        end
        if (en2) begin
            r2_kind <= r1_kind;
            r2_rgb  <= r1_rgb;
            r2_pf   <= n2_pf;
            r2_t    <= n2_t;
        end
        if (en3) begin
            r3_kind <= r2_kind;
            r3_rgb  <= r2_rgb;
            r3_pk   <= n3_pk;
            r3_t    <= r2_t;
        end
        if (en4) begin
            r4_kind <= r3_kind;
            r4_rgb  <= r3_rgb;
            r4_p    <= n4_p;
            r4_d    <= n4_d;
            r4_k    <= n4_k;
            r4_seg  <= n4_seg;
        end
        if (en5) begin
            r5_kind <= r4_kind;
            r5_rgb  <= r4_rgb;
            r5_p    <= r4_p;
            r5_ph   <= n5_ph;
            r5_seg  <= r4_seg;
        end
    end

    // Final channel values: v on the hue curve, then (255 * v) >> 16.
    always_comb begin
        logic [16:0] v;
        logic [24:0] s;
        logic [7:0]  ch [3];
        for (int c = 0; c < 3; c++) begin
            unique case (r5_seg[c])
                SEG_RISE, SEG_FALL: v = r5_p + 17'(r5_ph[c]);
                SEG_HIGH:           v = Q_ONE;
                SEG_LOW:            v = r5_p;
                default:            v = r5_p;
            endcase
            s = {v, 8'd0} - 25'(v);
            ch[c] = (s[24:16] > 9'd255) ? 8'd255 : s[23:16];
        end
        if (r5_kind == KIND_HUE || r5_kind == KIND_TEMP) begin
            o_rgb = '{red: ch[0], green: ch[1], blue: ch[2]};
        end else begin
            o_rgb = r5_rgb;
        end
    end

    assign o_valid = r5_v;

endmodule

// ===== hw/rtl/wsenc_queue.sv =====
// Small FIFO of converted colors between the front end and the serializer.
module wsenc_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  wsenc_pkg::t_rgb i_data,
    output logic            o_valid,
    input  logic            i_pop,
    output wsenc_pkg::t_rgb o_data
);
    import wsenc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rgb             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/wsenc_back.sv =====
// Back end: encodes one color into 72 line bits and sends them as nine bytes.
module wsenc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  wsenc_pkg::t_rgb i_q_data,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_line_byte,
    output logic            o_last
);
    import wsenc_pkg::*;

    // Green, red, blue, MSB first; each color bit becomes 1, bit, 0.
    function automatic logic [71:0] encode(input t_rgb c);
        logic [23:0] seq;
        logic [71:0] f;
        seq = {c.green, c.red, c.blue};
        for (int j = 0; j < 24; j++) begin
            f[3*j]     = 1'b1;
            f[3*j + 1] = seq[23 - j];
            f[3*j + 2] = 1'b0;
        end
        return f;
    endfunction

    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [63:0] r_frame;
    logic        r_ov;
    logic [7:0]  r_byte;
    logic        r_last;

    logic [71:0] src;
    logic        src_v, adv, fire, is_last;

    assign src     = r_busy ? {8'd0, r_frame} : encode(i_q_data);
    assign src_v   = r_busy || i_q_valid;
    assign adv     = !r_ov || i_ready;
    assign fire    = adv && src_v;
    assign is_last = (r_cnt == LAST_BYTE);
    assign o_q_pop = fire && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else if (fire) begin
            r_busy <= !is_last;
            r_cnt  <= is_last ? 4'd0 : r_cnt + 4'd1;
            r_ov   <= 1'b1;
        end else if (adv) begin
            r_ov   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_frame <= src[71:8];
            r_byte  <= src[7:0];
            r_last  <= is_last;
        end
    end

    assign o_valid     = r_ov;
    assign o_line_byte = r_byte;
    assign o_last      = r_last;

endmodule

// ===== hw/rtl/ws2812_color_command_encoder_core.sv =====
// Top level of the WS2812 color command encoder.
// The block takes one color command per item (direct RGB, hue with
// saturation, color temperature in mireds, or a gray level) and produces a
// frame of nine line bytes for a serial transmitter, the ninth flagged by
// o_last. Hue and temperature commands are converted to RGB in a five-stage
// fixed-point pipeline; the green, red and blue channels are then sent MSB
// first, each color bit becoming the line bits 1,1,0 for a one or 1,0,0 for
// a zero, with the first line bit in bit 0 of the first byte. At the
// sustained rate, while the consumer is ready, the block delivers one byte
// per cycle, set by the single byte-wide output of the serializer; a new
// command is accepted every cycle while the converter pipeline and the color
// queue have room, so commands may arrive in bursts. When the queue is empty
// and the serializer is idle, the first byte of a command's frame is offered
// on the output once the command has passed the five pipeline registers,
// the color queue and the output byte register. Both channels use a valid
// and ready handshake and the output byte is registered, so a stalled
// consumer does not stall the converter until the queue fills.
module ws2812_color_command_encoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_hue,
    input  logic [7:0]  i_saturation,
    input  logic [15:0] i_color_temp,
    input  logic [7:0]  i_level,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_line_byte,
    output logic        o_last
);
    import wsenc_pkg::*;

    // Converted color from the front end into the queue.
    logic fr_valid;
    logic fr_ready;
    t_rgb fr_rgb;

    // Queue head toward the serializer.
    logic q_valid;
    logic q_pop;
    t_rgb q_rgb;

    wsenc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_color_temp (i_color_temp),
        .i_level      (i_level),
        .o_valid      (fr_valid),
        .i_ready      (fr_ready),
        .o_rgb        (fr_rgb)
    );

    // The queue lets commands keep flowing while a frame is being sent.
    wsenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .o_ready (fr_ready),
        .i_data  (fr_rgb),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rgb)
    );

    // The serializer picks up the next color on the same cycle it sends the
    // last byte of the current one, so back-to-back frames have no gap.
    wsenc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_data    (q_rgb),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_line_byte (o_line_byte),
        .o_last      (o_last)
    );

endmodule

// ===== hw/rtl/wsenc_checker.sv =====
// Port-level checks of the color command encoder and their binding.
module wsenc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_line_byte,
    input logic        o_last
);
    import wsenc_pkg::*;

    logic       in_acc, out_acc;
    logic [3:0] r_byte_cnt;
    logic [4:0] r_pend;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
        end else if (out_acc) begin
            r_byte_cnt <= o_last ? 4'd0 : r_byte_cnt + 4'd1;
        end
    end

    // Commands taken whose frame has not been fully delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_acc && !(out_acc && o_last)) begin
            r_pend <= r_pend + 5'd1;
        end else if (!in_acc && out_acc && o_last) begin
            r_pend <= r_pend - 5'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_line_byte) && $stable(o_last))
        else $error("output item changed while stalled");

    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (o_last == (r_byte_cnt == LAST_BYTE)))
        else $error("frame is not nine bytes long");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pend != 5'd0))
        else $error("output item without an accepted command");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind ws2812_color_command_encoder_core wsenc_checker u_wsenc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_line_byte (o_line_byte),
    .o_last      (o_last)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the WS2812 color command encoder with its own frame predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wsenc_pkg::*;

    // One color command as the sender holds it. The hold flag makes the
    // sender wait with this item until every line byte due so far has come.
    typedef struct {
        t_kind       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  hue;
        logic [7:0]  saturation;
        logic [15:0] color_temp;
        logic [7:0]  level;
        bit          hold;
    } t_color_cmd;

    // One line byte of a frame as it should leave the block.
    typedef struct packed {
        logic [7:0] line_byte;
        logic       last;
    } t_frame_byte;

    // Q16 constants of the conversion, as signed 64-bit values so that the
    // arithmetic below never mixes signed and unsigned operands.
    localparam longint FX_ONE      = 65536;
    localparam longint FX_SIXTH    = 10922;
    localparam longint FX_THIRD    = 21845;
    localparam longint FX_HALF     = 32768;
    localparam longint FX_TWOTHIRD = 43690;
    localparam longint FX_TEMP_HUE = 5439;
    localparam longint FX_TEMP_K   = 26214;
    localparam int     FRAME_LEN   = 9;
    localparam int     RANDOM_CMDS = 440;
    // The limit leaves room for the slowest correct run, with every byte
    // waiting out the longest stall of the receiver.
    localparam int unsigned CYCLE_LIMIT = 600000;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [1:0]  i_kind       = KIND_RGB;
    logic [7:0]  i_red        = 8'd0;
    logic [7:0]  i_green      = 8'd0;
    logic [7:0]  i_blue       = 8'd0;
    logic [7:0]  i_hue        = 8'd0;
    logic [7:0]  i_saturation = 8'd0;
    logic [15:0] i_color_temp = 16'd0;
    logic [7:0]  i_level      = 8'd0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_line_byte;
    logic        o_last;

    ws2812_color_command_encoder_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_color_temp (i_color_temp),
        .i_level      (i_level),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_line_byte  (o_line_byte),
        .o_last       (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Commands still to be sent, and line bytes still to be received.
    t_color_cmd  cmds_to_send[$];
    t_frame_byte line_bytes_due[$];

    // Counters owned by one process each. The handshake counters are updated
    // with nonblocking assignments, so that the other side always reads last
    // cycle's value.
    int unsigned n_accepted  = 0;
    int unsigned bytes_owed  = 0;
    int unsigned bytes_taken = 0;
    int unsigned n_errors    = 0;

    // Two stretches of the run go without any idling on either side, so the
    // block is seen at its full rate with its queue under steady load.
    wire full_rate = (n_accepted >= 120 && n_accepted < 200) ||
                     (n_accepted >= 330 && n_accepted < 370);

    // Length of an idle stretch: mostly none, often a few cycles, now and
    // then a long one.
    function automatic int idle_length(bit no_idle);
        int unsigned pick;
        if (no_idle) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            return 0;
        end else if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // One point of the hue function for saturation one: q is 1.0 and the
    // span q - p is never negative, since lightness is at least one half.
    function automatic longint hue_point(longint p, longint t);
        longint span;
        span = FX_ONE - p;
        if (t < 0) begin
            t = t + FX_ONE;
        end
        if (t > FX_ONE) begin
            t = t - FX_ONE;
        end
        if (t < FX_SIXTH) begin
            return p + ((span * 6 * t) >>> 16);
        end else if (t < FX_HALF) begin
            return FX_ONE;
        end else if (t < FX_TWOTHIRD) begin
            return p + ((span * (FX_TWOTHIRD - t) * 6) >>> 16);
        end
        return p;
    endfunction

    // Scales a Q16 channel level to 0..255 with truncation and saturation.
    function automatic logic [7:0] channel_value(longint v);
        longint scaled;
        if (v < 0) begin
            v = 0;
        end
        scaled = (255 * v) >>> 16;
        if (scaled > 255) begin
            scaled = 255;
        end
        return scaled[7:0];
    endfunction

    // The 24-bit color that a command asks for.
    function automatic t_rgb color_of_command(t_color_cmd cmd);
        t_rgb   rgb;
        longint hue_q;
        longint frac;
        longint light;
        longint p;
        longint sat;
        longint mireds;
        case (cmd.kind)
            KIND_RGB: begin
                rgb.red   = cmd.red;
                rgb.green = cmd.green;
                rgb.blue  = cmd.blue;
                return rgb;
            end
            KIND_GRAY: begin
                rgb.red   = cmd.level;
                rgb.green = cmd.level;
                rgb.blue  = cmd.level;
                return rgb;
            end
            KIND_HUE: begin
                sat   = (cmd.saturation > SAT_MAX) ? longint'(SAT_MAX) : longint'(cmd.saturation);
                hue_q = (longint'(cmd.hue) << 16) / 254;
                frac  = (sat << 16) / 254;
                light = FX_ONE - (frac >>> 1);
            end
            default: begin
                mireds = (cmd.color_temp > TEMP_MAX) ? longint'(TEMP_MAX)
                                                     : longint'(cmd.color_temp);
                hue_q  = FX_TEMP_HUE;
                frac   = (mireds << 16) / 500;
                light  = FX_ONE - ((frac * FX_TEMP_K) >>> 16);
            end
        endcase
        p = 2 * light - FX_ONE;
        rgb.red   = channel_value(hue_point(p, hue_q + FX_THIRD));
        rgb.green = channel_value(hue_point(p, hue_q));
        rgb.blue  = channel_value(hue_point(p, hue_q - FX_THIRD));
        return rgb;
    endfunction

    // The 72 line bits of a command, first line bit in bit 0. Colors go out
    // green, red, blue, MSB first; each color bit becomes 1, bit, 0.
    function automatic logic [71:0] line_bits_of_command(t_color_cmd cmd);
        t_rgb        rgb;
        logic [23:0] grb;
        logic [71:0] bits;
        rgb  = color_of_command(cmd);
        grb  = {rgb.green, rgb.red, rgb.blue};
        bits = '0;
        for (int k = 0; k < 24; k++) begin
            bits[3 * k]     = 1'b1;
            bits[3 * k + 1] = grb[23 - k];
        end
        return bits;
    endfunction

    // A command with every field random; the unused fields stay random in
    // directed items too, since the block must ignore them.
    function automatic t_color_cmd random_command();
        t_color_cmd cmd;
        cmd.kind       = t_kind'($urandom_range(0, 3));
        cmd.red        = 8'($urandom);
        cmd.green      = 8'($urandom);
        cmd.blue       = 8'($urandom);
        cmd.hue        = 8'($urandom);
        cmd.saturation = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(250, 255)) : 8'($urandom);
        case ($urandom_range(0, 2))
            0:       cmd.color_temp = 16'($urandom_range(0, 500));
            1:       cmd.color_temp = 16'($urandom_range(490, 512));
            default: cmd.color_temp = 16'($urandom);
        endcase
        cmd.level = 8'($urandom);
        cmd.hold  = 1'b0;
        return cmd;
    endfunction

    // Sender. Valid rises on its own; once high it holds, with the same
    // payload, until the item is taken. After each item a random gap.
    t_color_cmd on_wire;
    int         send_gap = 0;

    always @(posedge i_clk) begin : send_commands
        logic [71:0] bits;
        t_frame_byte due;
        t_color_cmd  next_cmd;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && o_ready) begin
                bits = line_bits_of_command(on_wire);
                for (int b = 0; b < FRAME_LEN; b++) begin
                    due.line_byte = bits[8 * b +: 8];
                    due.last      = (b == FRAME_LEN - 1);
                    line_bytes_due.push_back(due);
                end
                bytes_owed <= bytes_owed + FRAME_LEN;
                n_accepted <= n_accepted + 1;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    i_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (cmds_to_send.size() != 0 &&
                             !(cmds_to_send[0].hold &&
                               (i_valid || bytes_owed != bytes_taken))) begin
                    next_cmd     = cmds_to_send.pop_front();
                    on_wire      <= next_cmd;
                    i_kind       <= next_cmd.kind;
                    i_red        <= next_cmd.red;
                    i_green      <= next_cmd.green;
                    i_blue       <= next_cmd.blue;
                    i_hue        <= next_cmd.hue;
                    i_saturation <= next_cmd.saturation;
                    i_color_temp <= next_cmd.color_temp;
                    i_level      <= next_cmd.level;
                    i_valid      <= 1'b1;
                    send_gap     <= idle_length(full_rate);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Ready drops for random stretches, independent of o_valid, so
    // that stalls land on every byte of a frame.
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready    <= 1'b1;
            stall_left <= idle_length(full_rate);
        end
    end

    // Checker: every byte taken is compared with the oldest one due.
    always @(posedge i_clk) begin : check_line_bytes
        t_frame_byte due;
        if (i_rst_n && o_valid && i_ready) begin
            bytes_taken <= bytes_taken + 1;
            if (line_bytes_due.size() == 0) begin
                $error("line byte %02h (last %0b) with no item pending", o_line_byte, o_last);
                n_errors++;
            end else begin
                due = line_bytes_due.pop_front();
                if (o_line_byte !== due.line_byte) begin
                    $error("line_byte: expected %02h, got %02h", due.line_byte, o_line_byte);
                    n_errors++;
                end
                if (o_last !== due.last) begin
                    $error("last: expected %0b, got %0b", due.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    // Stimulus: a directed opening, then random commands. The first random
    // item and one in the middle wait until the block has drained.
    initial begin : stimulus
        t_color_cmd cmd;

        // Direct RGB at the extremes and with alternating bit patterns.
        cmd = random_command(); cmd.kind = KIND_RGB;
        cmd.red = 8'h00; cmd.green = 8'h00; cmd.blue = 8'h00; cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_RGB;
        cmd.red = 8'hFF; cmd.green = 8'hFF; cmd.blue = 8'hFF; cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_RGB;
        cmd.red = 8'hAA; cmd.green = 8'h55; cmd.blue = 8'h0F; cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_RGB;
        cmd.red = 8'h01; cmd.green = 8'h80; cmd.blue = 8'hF0; cmds_to_send.push_back(cmd);

        // Gray levels.
        cmd = random_command(); cmd.kind = KIND_GRAY; cmd.level = 8'h00; cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_GRAY; cmd.level = 8'hFF; cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_GRAY; cmd.level = 8'h5A; cmds_to_send.push_back(cmd);

        // Hue commands: zero and full saturation, the clamp above 254, the
        // wrap at hue 255, and points on each piece of the hue function.
        cmd = random_command(); cmd.kind = KIND_HUE;
        cmd.hue = 8'd0;   cmd.saturation = 8'd0;   cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_HUE;
        cmd.hue = 8'd0;   cmd.saturation = 8'd254; cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_HUE;
        cmd.hue = 8'd255; cmd.saturation = 8'd255; cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_HUE;
        cmd.hue = 8'd254; cmd.saturation = 8'd200; cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_HUE;
        cmd.hue = 8'd42;  cmd.saturation = 8'd254; cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_HUE;
        cmd.hue = 8'd85;  cmd.saturation = 8'd128; cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_HUE;
        cmd.hue = 8'd127; cmd.saturation = 8'd255; cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_HUE;
        cmd.hue = 8'd170; cmd.saturation = 8'd100; cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_HUE;
        cmd.hue = 8'd211; cmd.saturation = 8'd1;   cmds_to_send.push_back(cmd);

        // Color temperature: both ends, the clamp just above 500, full scale.
        cmd = random_command(); cmd.kind = KIND_TEMP; cmd.color_temp = 16'd0;     cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_TEMP; cmd.color_temp = 16'd250;   cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_TEMP; cmd.color_temp = 16'd500;   cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_TEMP; cmd.color_temp = 16'd501;   cmds_to_send.push_back(cmd);
        cmd = random_command(); cmd.kind = KIND_TEMP; cmd.color_temp = 16'hFFFF;  cmds_to_send.push_back(cmd);

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            cmd = random_command();
            cmd.hold = (n == 0) || (n == RANDOM_CMDS / 2);
            cmds_to_send.push_back(cmd);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_to_send.size() != 0 || i_valid || line_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        // Extra cycles past the pipeline depth to catch stray bytes.
        repeat (40) @(posedge i_clk);

        if (n_errors == 0 && line_bytes_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
